### hdl/extended_gcd_bezout_core_defines.svh
// Assertion macros shared by the extended gcd core.
`ifndef EXTENDED_GCD_BEZOUT_CORE_DEFINES_SVH
`define EXTENDED_GCD_BEZOUT_CORE_DEFINES_SVH

// Plain condition, checked at every clock edge outside reset.
`define EGCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/egcd_pkg.sv
package egcd_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_UPD,
    ST_FIN
  } egcd_state_t;

  // Commands from the sequencer to the datapath and the output register.
  typedef struct packed {
    logic load;
    logic align;
    logic sub;
    logic upd;
    logic deliver;
  } egcd_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic b_zero;
    logic fits;
    logic k_zero;
    logic rem_zero;
  } egcd_stat_t;

endpackage

### hdl/extended_gcd_bezout_core.sv
// Extended Euclidean core: for signed operands a and b it returns the
// non-negative gcd g and coefficients x, y with a*x + b*y = g.
//
// Input channel (in_*): one beat carries operand_a and operand_b. Result
// channel (out_*): one beat per input beat carries gcd_value, coef_a and
// coef_b, in input order.
//
// One operand pair is worked at a time; in_tready is high only while the
// core is idle. Each Euclid step runs on one shared shift/subtract unit:
// the divisor is shifted up one bit per cycle until it is aligned, then one
// quotient bit per cycle is taken while the coefficient products build up,
// then the remainders and coefficients are updated. When operand_b is zero
// the core goes straight from the load to the delivery of the result.
//
// The result sits in an output register, so a stalled receiver only holds
// the core once a second result is ready. Reset clears the sequencer and
// the output valid; no clearing pass is needed.
module extended_gcd_bezout_core #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF,
  localparam int IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * DATA_WIDTH - 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // operand_a, operand_b (from bit 0 up), zero padded
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // gcd_value, coef_a, coef_b (from bit 0 up), zero padded
  output logic [OUT_W-1:0] out_tdata
);

  egcd_pkg::egcd_cmd_t   cmd;
  egcd_pkg::egcd_stat_t  stat;
  logic                  out_free;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r;
  logic [DATA_WIDTH-2:0] res_gcd;
  logic [DATA_WIDTH-1:0] res_coef_a, res_coef_b;

  assign out_free = !out_valid_r || out_tready;

  egcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  egcd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .op_a       (in_tdata[DATA_WIDTH-1:0]),
    .op_b       (in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .stat       (stat),
    .res_gcd    (res_gcd),
    .res_coef_a (res_coef_a),
    .res_coef_b (res_coef_b)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.deliver) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_data_r <= OUT_W'({res_coef_b, res_coef_a, res_gcd});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/egcd_ctrl.sv
`include "extended_gcd_bezout_core_defines.svh"

module egcd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  egcd_pkg::egcd_stat_t stat,
  output logic                 in_ready,
  output egcd_pkg::egcd_cmd_t  cmd
);

  egcd_pkg::egcd_state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= egcd_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      egcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          st_nxt = stat.b_zero ? egcd_pkg::ST_FIN : egcd_pkg::ST_ALIGN;
        end
      end
      egcd_pkg::ST_ALIGN: begin
        if (!stat.fits) begin
          st_nxt = egcd_pkg::ST_SUB;
        end
      end
      egcd_pkg::ST_SUB: begin
        if (stat.k_zero) begin
          st_nxt = egcd_pkg::ST_UPD;
        end
      end
      egcd_pkg::ST_UPD: begin
        st_nxt = stat.rem_zero ? egcd_pkg::ST_FIN : egcd_pkg::ST_ALIGN;
      end
      egcd_pkg::ST_FIN: begin
        if (out_free) begin
          st_nxt = egcd_pkg::ST_IDLE;
        end
      end
      default: st_nxt = egcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (st_r)
      egcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      egcd_pkg::ST_ALIGN: cmd.align = 1'b1;
      egcd_pkg::ST_SUB:   cmd.sub = 1'b1;
      egcd_pkg::ST_UPD:   cmd.upd = 1'b1;
      egcd_pkg::ST_FIN:   cmd.deliver = out_free;
      default:            cmd = '0;
    endcase
  end

  `EGCD_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.align, cmd.sub, cmd.upd, cmd.deliver}), "egcd_ctrl: more than one command active")

endmodule

### hdl/egcd_datapath.sv
`include "extended_gcd_bezout_core_defines.svh"

module egcd_datapath #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  egcd_pkg::egcd_cmd_t         cmd,
  input  logic signed [DATA_WIDTH-1:0] op_a,
  input  logic signed [DATA_WIDTH-1:0] op_b,
  output egcd_pkg::egcd_stat_t        stat,
  output logic [DATA_WIDTH-2:0]       res_gcd,
  output logic [DATA_WIDTH-1:0]       res_coef_a,
  output logic [DATA_WIDTH-1:0]       res_coef_b
);

  localparam int KW = $clog2(DATA_WIDTH);

  // Remainder magnitudes: n_r is the running dividend, d_r the divisor and
  // dsh_r the divisor aligned under the dividend.
  logic [DATA_WIDTH-1:0] n_r, n_nxt, d_r, d_nxt, dsh_r, dsh_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic                  sp_r, sp_nxt, sc_r, sc_nxt;
  logic [DATA_WIDTH-1:0] px_r, px_nxt, cx_r, cx_nxt;
  logic [DATA_WIDTH-1:0] py_r, py_nxt, cy_r, cy_nxt;
  logic [DATA_WIDTH-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic                  ge;

  assign mag_a = op_a[DATA_WIDTH-1] ? DATA_WIDTH'(-op_a) : op_a;
  assign mag_b = op_b[DATA_WIDTH-1] ? DATA_WIDTH'(-op_b) : op_b;
  assign ge    = (dsh_r <= n_r);

  assign stat.b_zero   = (op_b == '0);
  assign stat.fits     = ({dsh_r, 1'b0} <= {1'b0, n_r});
  assign stat.k_zero   = (k_r == '0);
  assign stat.rem_zero = (n_r == '0);

  always_comb begin
    n_nxt   = n_r;
    d_nxt   = d_r;
    dsh_nxt = dsh_r;
    k_nxt   = k_r;
    sp_nxt  = sp_r;
    sc_nxt  = sc_r;
    px_nxt  = px_r;
    cx_nxt  = cx_r;
    py_nxt  = py_r;
    cy_nxt  = cy_r;
    qx_nxt  = qx_r;
    qy_nxt  = qy_r;
    if (cmd.load) begin
      n_nxt   = mag_a;
      d_nxt   = mag_b;
      dsh_nxt = mag_b;
      k_nxt   = '0;
      sp_nxt  = op_a[DATA_WIDTH-1];
      sc_nxt  = op_b[DATA_WIDTH-1];
      px_nxt  = DATA_WIDTH'(1);
      cx_nxt  = '0;
      py_nxt  = '0;
      cy_nxt  = DATA_WIDTH'(1);
      qx_nxt  = '0;
      qy_nxt  = '0;
    end else if (cmd.align) begin
      if (stat.fits) begin
        dsh_nxt = {dsh_r[DATA_WIDTH-2:0], 1'b0};
        k_nxt   = k_r + KW'(1);
      end
    end else if (cmd.sub) begin
      // One quotient bit per cycle, most significant first; the products
      // q*cur_x and q*cur_y build up in Horner form alongside.
      if (ge) begin
        n_nxt = n_r - dsh_r;
      end
      qx_nxt = {qx_r[DATA_WIDTH-2:0], 1'b0} + (ge ? cx_r : '0);
      qy_nxt = {qy_r[DATA_WIDTH-2:0], 1'b0} + (ge ? cy_r : '0);
      if (!stat.k_zero) begin
        dsh_nxt = {1'b0, dsh_r[DATA_WIDTH-1:1]};
        k_nxt   = k_r - KW'(1);
      end
    end else if (cmd.upd) begin
      // The quotient is negative when dividend and divisor differ in sign.
      // The remainder keeps the sign of the dividend.
      cx_nxt  = (sp_r ^ sc_r) ? px_r + qx_r : px_r - qx_r;
      cy_nxt  = (sp_r ^ sc_r) ? py_r + qy_r : py_r - qy_r;
      px_nxt  = cx_r;
      py_nxt  = cy_r;
      n_nxt   = d_r;
      d_nxt   = n_r;
      dsh_nxt = n_r;
      k_nxt   = '0;
      qx_nxt  = '0;
      qy_nxt  = '0;
      sp_nxt  = sc_r;
      sc_nxt  = sp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    dsh_r <= dsh_nxt;
    sp_r  <= sp_nxt;
    sc_r  <= sc_nxt;
    px_r  <= px_nxt;
    cx_r  <= cx_nxt;
    py_r  <= py_nxt;
    cy_r  <= cy_nxt;
    qx_r  <= qx_nxt;
    qy_r  <= qy_nxt;
  end

  // A negative last remainder flips both coefficients; the gcd is its magnitude.
  assign res_gcd    = n_r[DATA_WIDTH-2:0];
  assign res_coef_a = sp_r ? DATA_WIDTH'(-px_r) : px_r;
  assign res_coef_b = sp_r ? DATA_WIDTH'(-py_r) : py_r;

  `EGCD_ASSERT(a_div_nonzero, !(cmd.align || cmd.sub) || (d_r != '0), "egcd_datapath: division by zero")
  `EGCD_ASSERT(a_rem_below_div, !cmd.upd || (n_r < d_r), "egcd_datapath: remainder not below divisor")
  `EGCD_ASSERT_NEXT(a_align_bound, cmd.align && stat.fits, dsh_r <= n_r, "egcd_datapath: aligned divisor exceeds dividend")

endmodule

### verif/tb_extended_gcd_bezout_core.sv
module tb_extended_gcd_bezout_core;

  localparam int DW = egcd_pkg::DATA_WIDTH_DEF;
  localparam int IN_W = ((2 * DW + 7) / 8) * 8;
  localparam int OUT_W = ((3 * DW - 1 + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_BEATS = 64;
  localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};

  typedef enum int unsigned {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_t;

  // Packed so that operand a lands in the low bits of in_tdata.
  typedef struct packed {
    logic [DW-1:0] b;
    logic [DW-1:0] a;
  } operand_pair_t;

  typedef struct {
    logic [DW-2:0] gcd_value;
    logic [DW-1:0] coef_a;
    logic [DW-1:0] coef_b;
  } bezout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  operand_pair_t pending_operands[$];
  bezout_t expected_bezout[$];
  int unsigned total_items = 0;
  int unsigned sent_cnt = 0;
  int unsigned mismatch_cnt = 0;

  extended_gcd_bezout_core #(
    .DATA_WIDTH(DW)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Euclid's remainder sequence with truncating division; the coefficient
  // pairs start from the identity so the first step needs no special case.
  function automatic bezout_t predict_bezout(logic [DW-1:0] a_bits, logic [DW-1:0] b_bits);
    longint r0, r1, x0, x1, y0, y1, q, t;
    bezout_t res;
    r0 = $signed(a_bits);
    r1 = $signed(b_bits);
    x0 = 1;
    x1 = 0;
    y0 = 0;
    y1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1;
      r0 = r1;
      r1 = t;
      t = x0 - q * x1;
      x0 = x1;
      x1 = t;
      t = y0 - q * y1;
      y0 = y1;
      y1 = t;
    end
    if (r0 < 0) begin
      r0 = -r0;
      x0 = -x0;
      y0 = -y0;
    end
    res.gcd_value = r0[DW-2:0];
    res.coef_a = x0[DW-1:0];
    res.coef_b = y0[DW-1:0];
    return res;
  endfunction

  function automatic idle_phase_t current_phase();
    return idle_phase_t'((sent_cnt / PHASE_BEATS) % 4);
  endfunction

  function automatic int unsigned idle_pct(bit recv_side);
    case (current_phase())
      PH_SEND_IDLE:  return recv_side ? 0 : 79;
      PH_RECV_STALL: return recv_side ? 79 : 0;
      PH_BOTH:       return 25;
      default:       return 0;
    endcase
  endfunction

  function automatic logic [DW-1:0] apply_sign(logic [DW-1:0] v);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Magnitude spread over all bit lengths; the most negative value is never made.
  function automatic logic [DW-1:0] rand_operand();
    logic [DW-1:0] v;
    v = $urandom() >> $urandom_range(DW - 1);
    v[DW-1] = 1'b0;
    return apply_sign(v);
  endfunction

  function automatic logic [DW-1:0] fib_at(int unsigned k);
    logic [DW-1:0] f0, f1, t;
    f0 = 0;
    f1 = 1;
    repeat (k) begin
      t = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f0;
  endfunction

  task automatic push_pair(logic [DW-1:0] a, logic [DW-1:0] b);
    operand_pair_t p;
    p.a = a;
    p.b = b;
    pending_operands.push_back(p);
  endtask

  initial begin : fill_operands
    logic [DW-1:0] g, m, n;
    int unsigned k;
    push_pair(0, 0);
    push_pair(5, 0);
    push_pair(-5, 0);
    push_pair(0, 7);
    push_pair(0, -7);
    push_pair(MAX_POS, 0);
    push_pair(-MAX_POS, 0);
    push_pair(MAX_POS, MAX_POS);
    push_pair(MAX_POS, -MAX_POS);
    push_pair(-MAX_POS, -MAX_POS);
    push_pair(MAX_POS, 1);
    push_pair(1, MAX_POS);
    push_pair(-MAX_POS, 1);
    push_pair(MAX_POS, MAX_POS - 1);
    // Consecutive Fibonacci numbers give the longest remainder sequence.
    push_pair(1836311903, 1134903170);
    push_pair(-1836311903, 1134903170);
    push_pair(1134903170, -1836311903);
    push_pair(12, 18);
    push_pair(-12, 18);
    push_pair(12, -18);
    push_pair(-12, -18);
    push_pair(-7, 7);
    push_pair(-1, -1);
    push_pair(32'h5555_5555, 32'h2AAA_AAAA);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(9))
        0, 1, 2: push_pair(rand_operand(), rand_operand());
        3, 4: begin
          g = $urandom_range(1 << 15, 1);
          m = $urandom_range(1 << 15);
          n = $urandom_range(1 << 15);
          push_pair(apply_sign(g * m), apply_sign(g * n));
        end
        5, 6: begin
          k = $urandom_range(45, 1);
          if ($urandom_range(1))
            push_pair(apply_sign(fib_at(k + 1)), apply_sign(fib_at(k)));
          else
            push_pair(apply_sign(fib_at(k)), apply_sign(fib_at(k + 1)));
        end
        7: push_pair(apply_sign($urandom_range(20)), apply_sign($urandom_range(20)));
        8: begin
          if ($urandom_range(1))
            push_pair(rand_operand(), 0);
          else
            push_pair(0, rand_operand());
        end
        default: begin
          m = $urandom_range(1 << 16);
          n = $urandom_range(1 << 14);
          push_pair(apply_sign(m * n), apply_sign(m));
        end
      endcase
    end
    total_items = pending_operands.size();
  end

  always @(posedge clk) begin : drive_operands
    operand_pair_t pair;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pair = in_tdata;
        expected_bezout.push_back(predict_bezout(pair.a, pair.b));
        sent_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_operands.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          in_tdata <= pending_operands.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    bezout_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.gcd_value = out_tdata[DW-2:0];
        got.coef_a = out_tdata[2*DW-2:DW-1];
        got.coef_b = out_tdata[3*DW-2:2*DW-1];
        if (expected_bezout.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result beat: expected none, actual g=%0d x=%0d y=%0d",
                   $time, got.gcd_value, $signed(got.coef_a), $signed(got.coef_b));
        end else begin
          want = expected_bezout.pop_front();
          if (got.gcd_value !== want.gcd_value || got.coef_a !== want.coef_a ||
              got.coef_b !== want.coef_b) begin
            mismatch_cnt++;
            $display("%0t: result mismatch: expected g=%0d x=%0d y=%0d, actual g=%0d x=%0d y=%0d",
                     $time, want.gcd_value, $signed(want.coef_a), $signed(want.coef_b),
                     got.gcd_value, $signed(got.coef_a), $signed(got.coef_b));
          end
        end
      end
      out_tready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (sent_cnt < total_items || expected_bezout.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("extended_gcd_bezout_core: match");
    else
      $display("extended_gcd_bezout_core: mismatch");
    $finish;
  end

  initial begin
    #4000000;
    $display("extended_gcd_bezout_core: mismatch");
    $finish;
  end

endmodule
